// ----- rtl/mcss_pkg.sv -----
// Package for the Markov chain state sampler: sizes, function codes,
// controller state enum and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package mcss_pkg;

  localparam int MAX_STATES = 16;
  localparam int PROB_BITS  = 16;

  // Derived widths
  localparam int STATE_BITS = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int NUM_W      = $clog2(MAX_STATES + 1);
  localparam int ADDR_BITS  = 2 * STATE_BITS;
  localparam int TBL_DEPTH  = MAX_STATES * MAX_STATES;
  localparam int ACC_BITS   = PROB_BITS + NUM_W;

  // Port field widths
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 16;
  localparam int ONEHOT_W = 16;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_START = 2'd1;
  localparam logic [FUNC_W-1:0] FN_STEP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_t;

  // Table memory access from the controller
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [PROB_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } ram_req_t;

  // Finished result from the controller
  typedef struct packed {
    logic                  valid;
    logic [STATE_BITS-1:0] state;
  } res_t;

endpackage

// ----- rtl/mcss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mcss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mcss_ctrl.sv -----
// Sampler controller: item decode, current state, row scan with running sum.
// Depends on mcss_pkg; drives the table RAM through a ram_req_t.
`timescale 1ns / 1ps

module mcss_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_take,
  input  logic [mcss_pkg::FUNC_W-1:0]    func,
  input  logic [mcss_pkg::IDX_W-1:0]     from_state,
  input  logic [mcss_pkg::IDX_W-1:0]     to_state,
  input  logic [mcss_pkg::VAL_W-1:0]     probability,
  input  logic [mcss_pkg::IDX_W-1:0]     initial_state,
  input  logic [mcss_pkg::VAL_W-1:0]     rand_value,
  input  logic [mcss_pkg::NUM_W-1:0]     num_states,
  output logic                           busy,
  output mcss_pkg::ram_req_t             ram_req,
  input  logic [mcss_pkg::PROB_BITS-1:0] ram_rdata,
  output mcss_pkg::res_t                 res,
  input  logic                           res_take
);

  import mcss_pkg::*;

  ctrl_state_t           state, state_next;
  logic [STATE_BITS-1:0] current_state;
  logic [STATE_BITS-1:0] chk_col;
  logic [ACC_BITS-1:0]   accum;
  logic [PROB_BITS-1:0]  target;

  logic [ACC_BITS-1:0]   accum_next;
  logic                  hit;
  logic                  last_col;
  logic                  scan_done;
  logic [NUM_W-1:0]      start_ext;
  logic [STATE_BITS-1:0] start_state;
  logic                  load_in_range;

  // Datapath
  always_comb begin
    accum_next = accum + ACC_BITS'(ram_rdata);
    hit        = accum_next >= ACC_BITS'(target);
    last_col   = (NUM_W'(chk_col) == (num_states - NUM_W'(1)));
    scan_done  = hit || last_col;
    start_ext  = NUM_W'(initial_state);
    if (start_ext >= num_states) begin
      start_state = STATE_BITS'(num_states - NUM_W'(1));
    end else begin
      start_state = STATE_BITS'(initial_state);
    end
    load_in_range = (32'(from_state) < MAX_STATES) && (32'(to_state) < MAX_STATES);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && func == FN_START) begin
          state_next = ST_EMIT;
        end else if (in_take && func == FN_STEP) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy          = (state != ST_IDLE);
    res.valid     = (state == ST_EMIT);
    res.state     = current_state;
    ram_req.we    = (state == ST_IDLE) && in_take && (func == FN_LOAD) && load_in_range;
    ram_req.waddr = {STATE_BITS'(from_state), STATE_BITS'(to_state)};
    ram_req.wdata = PROB_BITS'(probability);
    ram_req.re    = 1'b0;
    ram_req.raddr = {current_state, STATE_BITS'(0)};
    unique case (state)
      ST_IDLE: ram_req.re = in_take && (func == FN_STEP);
      ST_SCAN: begin
        ram_req.re    = !scan_done;
        ram_req.raddr = {current_state, chk_col + STATE_BITS'(1)};
      end
      ST_EMIT: ram_req.re = 1'b0;
      default: ram_req.re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_state <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_take && func == FN_START) begin
        current_state <= start_state;
      end
      if (state == ST_SCAN && scan_done) begin
        current_state <= chk_col;
      end
    end
  end

  // Scan payload, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      chk_col <= '0;
      accum   <= '0;
      target  <= PROB_BITS'(rand_value);
    end else if (state == ST_SCAN) begin
      chk_col <= chk_col + STATE_BITS'(1);
      accum   <= accum_next;
    end
  end

endmodule

// ----- rtl/markov_chain_state_sampler.sv -----
// Top level of the Markov chain state sampler: config register, table RAM,
// controller and output register. Depends on mcss_pkg, mcss_ram, mcss_ctrl.
`timescale 1ns / 1ps

//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  input     | in_valid / in_stall  | func, from_state, to_state, probability,
//            |                      | initial_state, rand_value
//  output    | out_valid / out_stall| state_index, state_onehot
//  config    | cfg_wr_en            | cfg_wr_data (num_states)
//
// Sequence: a load is written to the table when it is taken; a start is
// accepted, then its result moves from the emit state into the output register.
// A step reads the current row one entry per cycle from the table RAM (one
// read port, registered read) until the running sum reaches the random value
// or the last column is read. The next item is taken once the result has
// moved into the output register, even if out_stall holds it there.
// Reset: current state 0, num_states = MAX_STATES, output empty. The table is
// not cleared; entries must be written before a step reads them.
// Stalls: out_stall only holds the output register; the controller waits in
// its emit state while that register is full and stalled.

module markov_chain_state_sampler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcss_pkg::FUNC_W-1:0]   func,
  input  logic [mcss_pkg::IDX_W-1:0]    from_state,
  input  logic [mcss_pkg::IDX_W-1:0]    to_state,
  input  logic [mcss_pkg::VAL_W-1:0]    probability,
  input  logic [mcss_pkg::IDX_W-1:0]    initial_state,
  input  logic [mcss_pkg::VAL_W-1:0]    rand_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcss_pkg::IDX_W-1:0]    state_index,
  output logic [mcss_pkg::ONEHOT_W-1:0] state_onehot,
  input  logic                          cfg_wr_en,
  input  logic [mcss_pkg::NUM_W-1:0]    cfg_wr_data
);

  import mcss_pkg::*;

  logic [NUM_W-1:0]     num_states;
  logic [NUM_W-1:0]     num_states_next;
  logic                 busy;
  logic                 in_take;
  ram_req_t             ram_req;
  logic [PROB_BITS-1:0] ram_rdata;
  res_t                 res;
  logic                 res_take;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;

  // Output register accepts a result when empty or when its transfer completes
  assign res_take = res.valid && (!out_valid || !out_stall);

  // num_states clamped to 1..MAX_STATES on write
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      num_states_next = NUM_W'(1);
    end else if (32'(cfg_wr_data) > MAX_STATES) begin
      num_states_next = NUM_W'(MAX_STATES);
    end else begin
      num_states_next = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= NUM_W'(MAX_STATES);
    end else if (cfg_wr_en) begin
      num_states <= num_states_next;
    end
  end

  mcss_ram #(
    .WIDTH(PROB_BITS),
    .DEPTH(TBL_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  mcss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_take      (in_take),
    .func         (func),
    .from_state   (from_state),
    .to_state     (to_state),
    .probability  (probability),
    .initial_state(initial_state),
    .rand_value   (rand_value),
    .num_states   (num_states),
    .busy         (busy),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .res          (res),
    .res_take     (res_take)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      state_index  <= IDX_W'(res.state);
      state_onehot <= ONEHOT_W'(1) << res.state;
    end
  end

  // Checks
  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    (num_states != '0) && (32'(num_states) <= MAX_STATES))
    else $error("num_states out of range");

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(state_onehot))
    else $error("state_onehot not one-hot");

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(res.valid))
    else $error("output loaded without a finished result");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> !res.valid)
    else $error("table write while a result is pending");

endmodule
